>>> sv/tufc_pkg.sv
// shared types and constants of the timestamped union-find connectivity unit
// field widths and positions, operation codes, sequencer states; no dependencies
package tufc_pkg;

    // fixed field widths of the stream payloads
    localparam int NODE_W       = 10;
    localparam int QTIME_W      = 24;
    localparam int OUT_CLOCK_W  = 24;

    // input tdata layout
    localparam int IN_A_LSB     = 0;
    localparam int IN_B_LSB     = IN_A_LSB + NODE_W;
    localparam int IN_QTIME_LSB = IN_B_LSB + NODE_W;
    localparam int IN_USED_W    = IN_QTIME_LSB + QTIME_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_CONN_LSB  = 0;
    localparam int OUT_MERGE_LSB = 1;
    localparam int OUT_CLOCK_LSB = 2;
    localparam int OUT_USED_W    = OUT_CLOCK_LSB + OUT_CLOCK_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // operation codes carried in s_tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [5:0] {
        ST_CLEAR      = 6'b000001,
        ST_IDLE       = 6'b000010,
        ST_WALK       = 6'b000100,
        ST_LINK_CHILD = 6'b001000,
        ST_LINK_ROOT  = 6'b010000,
        ST_DONE       = 6'b100000
    } state_t;

endpackage

>>> sv/tufc_node_ram.sv
// node store of the connectivity unit: one write port, one read port
// read data is registered; no dependencies
module tufc_node_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 45
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/timestamped_union_find_connectivity_unit.sv
// top level of the timestamped union-find connectivity unit
// uses tufc_pkg and tufc_node_ram
//
// sequence: an accept step, then one parent read per cycle for each endpoint
//   walk, two writes when two trees are linked, then the load of the output
//   register, which waits until that register is free
// throughput: one transaction at a time, set by the sequencer sharing one store read port
// invalid ids or a clear enable skip the walks and go straight to the result
// reset: a clearing pass over the node store, s_tready low meanwhile
module timestamped_union_find_connectivity_unit
    import tufc_pkg::*;
#(
    parameter int NODES      = 1024,
    parameter int TIME_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input transactions
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_a, node_b, query_time, zero pad
    input  logic [0:0]             s_tuser,   // operation
    // result transactions
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // connected, merged, edge_clock, zero pad
    // connect_enable register write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    // node store word: {link time, tree size, parent}
    localparam int ID_W     = $clog2(NODES);
    localparam int SIZE_W   = ID_W + 1;
    localparam int PAR_LSB  = 0;
    localparam int SIZE_LSB = PAR_LSB + ID_W;
    localparam int TIME_LSB = SIZE_LSB + SIZE_W;
    localparam int WORD_W   = TIME_LSB + TIME_WIDTH;
    // compare widths wide enough for both operands
    localparam int CMP_W    = ((ID_W > NODE_W) ? ID_W : NODE_W) + 1;
    localparam int TCMP_W   = (TIME_WIDTH > QTIME_W) ? TIME_WIDTH : QTIME_W;
    localparam logic [TIME_WIDTH-1:0] CLOCK_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [ID_W-1:0]       LAST_ID   = ID_W'(NODES - 1);
    localparam logic [CMP_W-1:0]      NODES_EXT = CMP_W'(NODES);

    // control state
    state_t                  state_reg, state_next;
    logic [ID_W-1:0]         clr_reg, clr_next;
    logic                    enable_reg;
    logic [TIME_WIDTH-1:0]   counter_reg, counter_next;
    logic                    out_valid_reg, out_valid_next;

    // per-transaction working registers
    logic                    op_reg, op_next;
    logic                    side_reg, side_next;        // 0 walking node_a, 1 node_b
    logic [ID_W-1:0]         cur_reg, cur_next;
    logic [ID_W-1:0]         nb_reg, nb_next;
    logic [QTIME_W-1:0]      qtime_reg, qtime_next;
    logic [ID_W-1:0]         ra_reg, ra_next;
    logic [SIZE_W-1:0]       sa_reg, sa_next;
    logic [ID_W-1:0]         child_reg, child_next;
    logic [ID_W-1:0]         root_reg, root_next;
    logic [SIZE_W-1:0]       sum_reg, sum_next;
    logic                    conn_reg, conn_next;
    logic                    merged_reg, merged_next;
    logic                    out_conn_reg, out_conn_next;
    logic                    out_merged_reg, out_merged_next;
    logic [OUT_CLOCK_W-1:0]  out_clock_reg, out_clock_next;

    // node store ports
    logic                    ram_we;
    logic [ID_W-1:0]         ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [ID_W-1:0]         ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;

    // input field decode
    logic [NODE_W-1:0]       in_a, in_b;
    logic [QTIME_W-1:0]      in_qtime;
    logic [CMP_W-1:0]        a_ext, b_ext;
    logic                    ids_ok;

    // read word decode
    logic [ID_W-1:0]         rd_par;
    logic [SIZE_W-1:0]       rd_size;
    logic [TIME_WIDTH-1:0]   rd_time;
    logic [CMP_W-1:0]        par_ext;
    logic [TCMP_W-1:0]       rd_time_ext, qtime_ext, counter_ext;
    logic                    walk_stop;

    assign in_a     = s_tdata[IN_A_LSB +: NODE_W];
    assign in_b     = s_tdata[IN_B_LSB +: NODE_W];
    assign in_qtime = s_tdata[IN_QTIME_LSB +: QTIME_W];
    assign a_ext    = CMP_W'(in_a);
    assign b_ext    = CMP_W'(in_b);
    // id 0 and ids past the last node are not nodes
    assign ids_ok   = (a_ext != '0) && (a_ext < NODES_EXT)
                   && (b_ext != '0) && (b_ext < NODES_EXT);

    assign rd_par      = ram_rdata[PAR_LSB +: ID_W];
    assign rd_size     = ram_rdata[SIZE_LSB +: SIZE_W];
    assign rd_time     = ram_rdata[TIME_LSB +: TIME_WIDTH];
    assign par_ext     = CMP_W'(rd_par);
    assign rd_time_ext = TCMP_W'(rd_time);
    assign qtime_ext   = TCMP_W'(qtime_reg);
    assign counter_ext = TCMP_W'(counter_reg);

    // a walk ends at a root, or for queries at a link newer than the asked time
    assign walk_stop = (rd_par == '0) || (par_ext >= NODES_EXT)
                    || ((op_reg == OP_QUERY) && (rd_time_ext > qtime_ext));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        m_tdata                                 = '0;
        m_tdata[OUT_CONN_LSB]                   = out_conn_reg;
        m_tdata[OUT_MERGE_LSB]                  = out_merged_reg;
        m_tdata[OUT_CLOCK_LSB +: OUT_CLOCK_W]   = out_clock_reg;
    end

    tufc_node_ram #(
        .DEPTH (NODES),
        .WIDTH (WORD_W)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        counter_next    = counter_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        op_next         = op_reg;
        side_next       = side_reg;
        cur_next        = cur_reg;
        nb_next         = nb_reg;
        qtime_next      = qtime_reg;
        ra_next         = ra_reg;
        sa_next         = sa_reg;
        child_next      = child_reg;
        root_next       = root_reg;
        sum_next        = sum_reg;
        conn_next       = conn_reg;
        merged_next     = merged_reg;
        out_conn_next   = out_conn_reg;
        out_merged_next = out_merged_reg;
        out_clock_next  = out_clock_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_reg;
        ram_wdata       = '0;
        ram_raddr       = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // every node a root of size one
                ram_we                       = 1'b1;
                ram_waddr                    = clr_reg;
                ram_wdata[SIZE_LSB +: SIZE_W] = SIZE_W'(1);
                clr_next                     = clr_reg + 1'b1;
                if (clr_reg == LAST_ID)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser[0];
                    qtime_next  = in_qtime;
                    nb_next     = b_ext[ID_W-1:0];
                    cur_next    = a_ext[ID_W-1:0];
                    ram_raddr   = a_ext[ID_W-1:0];
                    side_next   = 1'b0;
                    conn_next   = 1'b0;
                    merged_next = 1'b0;
                    // adds advance the clock even when the forest is left alone
                    if ((s_tuser[0] == OP_ADD) && (counter_reg != CLOCK_MAX))
                    begin
                        counter_next = counter_reg + 1'b1;
                    end
                    if (enable_reg && ids_ok)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                // ram_rdata holds the word of cur_reg
                if (!walk_stop)
                begin
                    cur_next  = rd_par;
                    ram_raddr = rd_par;
                end
                else if (!side_reg)
                begin
                    ra_next   = cur_reg;
                    sa_next   = rd_size;
                    side_next = 1'b1;
                    cur_next  = nb_reg;
                    ram_raddr = nb_reg;
                end
                else if (op_reg == OP_QUERY)
                begin
                    conn_next  = (ra_reg == cur_reg);
                    state_next = ST_DONE;
                end
                else if (ra_reg == cur_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // smaller tree goes under the larger; ties put node_b's root under
                    merged_next = 1'b1;
                    sum_next    = sa_reg + rd_size;
                    if (sa_reg < rd_size)
                    begin
                        root_next  = cur_reg;
                        child_next = ra_reg;
                    end
                    else
                    begin
                        root_next  = ra_reg;
                        child_next = cur_reg;
                    end
                    state_next = ST_LINK_CHILD;
                end
            end
            ST_LINK_CHILD:
            begin
                ram_we                           = 1'b1;
                ram_waddr                        = child_reg;
                ram_wdata[PAR_LSB +: ID_W]       = root_reg;
                ram_wdata[TIME_LSB +: TIME_WIDTH] = counter_reg;
                state_next                       = ST_LINK_ROOT;
            end
            ST_LINK_ROOT:
            begin
                ram_we                        = 1'b1;
                ram_waddr                     = root_reg;
                ram_wdata[SIZE_LSB +: SIZE_W] = sum_reg;
                state_next                    = ST_DONE;
            end
            ST_DONE:
            begin
                // output register frees up in the same cycle it is taken
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_conn_next   = conn_reg;
                    out_merged_next = merged_reg;
                    out_clock_next  = counter_ext[OUT_CLOCK_W-1:0];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            enable_reg    <= 1'b1;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        side_reg       <= side_next;
        cur_reg        <= cur_next;
        nb_reg         <= nb_next;
        qtime_reg      <= qtime_next;
        ra_reg         <= ra_next;
        sa_reg         <= sa_next;
        child_reg      <= child_next;
        root_reg       <= root_next;
        sum_reg        <= sum_next;
        conn_reg       <= conn_next;
        merged_reg     <= merged_next;
        out_conn_reg   <= out_conn_next;
        out_merged_reg <= out_merged_next;
        out_clock_reg  <= out_clock_next;
    end

endmodule

>>> sv/tufc_checker.sv
// port-level checks of the timestamped union-find connectivity unit
// uses tufc_pkg; bound to the top level at the end of this file
module tufc_checker
    import tufc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [OUT_CLOCK_W-1:0] last_clock_reg;
    logic [OUT_CLOCK_W-1:0] out_clock;

    assign out_clock = m_tdata[OUT_CLOCK_LSB +: OUT_CLOCK_W];

    // edge clock of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_clock_reg <= out_clock;
        end
    end

    // one transaction at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // a result is either a query answer or an add outcome, never both set
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_CONN_LSB] && m_tdata[OUT_MERGE_LSB]))
        else $error("connected and merged both set");

    // saturating edge clock never goes backward
    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_clock >= last_clock_reg))
        else $error("edge clock decreased");

    // stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind timestamped_union_find_connectivity_unit tufc_checker u_tufc_checker (.*);

>>> tb/sv/connectivity_checker.sv
// checker for the timestamped union-find connectivity unit: watches all three channels
// keeps its own forest, edge clock and enable bit, and compares every result transaction
// depends on tufc_pkg for field widths, field positions and operation codes
module connectivity_checker
    import tufc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_data,
    output int                     error_count,
    output int                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_COUNT = 1 << NODE_W;
    localparam logic [OUT_CLOCK_W-1:0] CLOCK_TOP = {OUT_CLOCK_W{1'b1}};

    typedef struct packed {
        logic                   connected;
        logic                   merged;
        logic [OUT_CLOCK_W-1:0] edge_clock;
    } answer_t;

    logic [NODE_W-1:0]      parent_of  [0:NODE_COUNT-1];
    logic [NODE_W:0]        tree_size  [0:NODE_COUNT-1];
    logic [OUT_CLOCK_W-1:0] link_stamp [0:NODE_COUNT-1];
    logic [OUT_CLOCK_W-1:0] edge_count;
    logic                   enable_q;
    answer_t                pending_answers [$];

    // walk to the root, optionally stopping at links newer than t
    function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] id, bit limited,
                                                     logic [QTIME_W-1:0] t);
        logic [NODE_W-1:0] cur;
        cur = id;
        for (int steps = 0; steps < NODE_COUNT; steps++)
        begin
            if (parent_of[cur] == '0)
                break;
            if (limited && link_stamp[cur] > t)
                break;
            cur = parent_of[cur];
        end
        return cur;
    endfunction

    // apply one request to the forest and return the answer it produces
    function automatic answer_t resolve_request(logic op, logic [NODE_W-1:0] a,
                                                logic [NODE_W-1:0] b, logic [QTIME_W-1:0] t);
        answer_t           ans;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        logic [NODE_W-1:0] swap;
        ans = '0;
        if (op == OP_ADD)
        begin
            if (edge_count != CLOCK_TOP)
                edge_count = edge_count + 1'b1;
            if (enable_q && a != '0 && b != '0)
            begin
                ra = find_root(a, 1'b0, '0);
                rb = find_root(b, 1'b0, '0);
                if (ra != rb)
                begin
                    if (tree_size[ra] < tree_size[rb])
                    begin
                        swap = ra;
                        ra   = rb;
                        rb   = swap;
                    end
                    parent_of[rb]  = ra;
                    tree_size[ra]  = tree_size[ra] + tree_size[rb];
                    link_stamp[rb] = edge_count;
                    ans.merged     = 1'b1;
                end
            end
        end
        else if (enable_q && a != '0 && b != '0)
        begin
            ans.connected = (find_root(a, 1'b1, t) == find_root(b, 1'b1, t));
        end
        ans.edge_clock = edge_count;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        answer_t want;
        answer_t got;
        answer_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                parent_of[i]  = '0;
                tree_size[i]  = {{NODE_W{1'b0}}, 1'b1};
                link_stamp[i] = '0;
            end
            edge_count = '0;
            enable_q   = 1'b1;
            pending_answers.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.connected  = m_tdata[OUT_CONN_LSB];
                got.merged     = m_tdata[OUT_MERGE_LSB];
                got.edge_clock = m_tdata[OUT_CLOCK_LSB +: OUT_CLOCK_W];
                if (pending_answers.size() == 0)
                begin
                    $error("result with no pending request: tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got.connected !== want.connected)
                    begin
                        $error("connected: expected %0d, actual %0d",
                               want.connected, got.connected);
                        error_count++;
                    end
                    if (got.merged !== want.merged)
                    begin
                        $error("merged: expected %0d, actual %0d", want.merged, got.merged);
                        error_count++;
                    end
                    if (got.edge_clock !== want.edge_clock)
                    begin
                        $error("edge_clock: expected %0d, actual %0d",
                               want.edge_clock, got.edge_clock);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                enable_q = cfg_data;
            if (s_tvalid && s_tready)
            begin
                fresh = resolve_request(s_tuser[0],
                                        s_tdata[IN_A_LSB +: NODE_W],
                                        s_tdata[IN_B_LSB +: NODE_W],
                                        s_tdata[IN_QTIME_LSB +: QTIME_W]);
                pending_answers.insert(pending_answers.size(), fresh);
            end
            pending_count = pending_answers.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// top of the testbench for the timestamped union-find connectivity unit
// drives requests, results back-pressure and enable writes; checking sits in connectivity_checker
// depends on tufc_pkg, connectivity_checker and the unit's rtl
module testbench
    import tufc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // quiet cycles allowed: covers the clearing pass after reset and the long hold-off
    localparam int QUIET_LIMIT  = 8000;
    localparam int HOLD_CYCLES  = 400;
    localparam int CLUSTER_SPAN = 48;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data  = 1'b0;

    int error_count;
    int pending_count;

    // stimulus shaping knobs, changed only between transactions
    int   send_idle_pct  = 31;
    int   recv_idle_pct  = 80;
    logic pressure_req   = 1'b0;
    int   hold_count     = 0;
    int   quiet_cycles   = 0;
    int   adds_sent      = 0;
    int   cluster_base   = 1;

    always #5 clk = ~clk;

    timestamped_union_find_connectivity_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    connectivity_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    // result side: random back-pressure, plus one long hold-off once requested
    always @(negedge clk)
    begin
        if (pressure_req && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: any cycle with no transaction on any channel counts toward the limit
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // offer one request and return at the edge where it is accepted
    task automatic offer_request(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                 logic [QTIME_W-1:0] t);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_A_LSB +: NODE_W]      = a;
        word[IN_B_LSB +: NODE_W]      = b;
        word[IN_QTIME_LSB +: QTIME_W] = t;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_ADD)
            adds_sent++;
    endtask

    // stop offering and wait until every result transaction has come back
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // enable register write; issued after a drain, but the first comes during the clearing pass
    task automatic set_connect_enable(logic value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random request: mostly adds and queries inside a small node cluster so trees
    // grow deep and queries hit real link times, the rest full-range noise
    task automatic random_request(int index);
        int                sel;
        logic              op;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [QTIME_W-1:0] t;
        if (index % CLUSTER_SPAN == 0)
            cluster_base = $urandom_range(1, (1 << NODE_W) - CLUSTER_SPAN);
        sel = $urandom_range(99);
        op  = (sel < 55) ? OP_ADD : OP_QUERY;
        a   = NODE_W'(cluster_base + int'($urandom_range(CLUSTER_SPAN - 1)));
        b   = NODE_W'(cluster_base + int'($urandom_range(CLUSTER_SPAN - 1)));
        t   = QTIME_W'($urandom_range(adds_sent));
        if (sel >= 90)
        begin
            // noise: any op, any id including the invalid zero, any time
            op = 1'($urandom_range(1));
            a  = NODE_W'($urandom_range((1 << NODE_W) - 1));
            b  = ($urandom_range(9) == 0) ? '0 : NODE_W'($urandom_range((1 << NODE_W) - 1));
            t  = QTIME_W'($urandom);
        end
        else if (sel >= 80)
        begin
            t = QTIME_W'(adds_sent);
        end
        else if (sel >= 70)
        begin
            t = QTIME_W'($urandom);
        end
        if (op == OP_ADD)
            t = QTIME_W'($urandom);
        offer_request(op, a, b, t);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase with the sender idling lightly and the receiver heavily
        set_connect_enable(1'b1);

        // directed: empty forest, merges, same tree, self edge, invalid ids
        offer_request(OP_QUERY, 10'd1, 10'd2, 24'd0);
        offer_request(OP_ADD, 10'd1, 10'd2, 24'hFFFFFF);
        offer_request(OP_ADD, 10'd2, 10'd1, 24'd0);
        offer_request(OP_ADD, 10'd3, 10'd3, 24'd0);
        offer_request(OP_ADD, 10'd0, 10'd5, 24'd0);
        offer_request(OP_ADD, 10'd5, 10'd0, 24'd0);
        offer_request(OP_ADD, 10'd1023, 10'd1022, 24'd0);
        // equal sizes: root of node_b goes under root of node_a
        offer_request(OP_ADD, 10'd1023, 10'd1, 24'd0);
        // time-limited walks before, at and after the link stamps
        offer_request(OP_QUERY, 10'd1, 10'd1022, 24'd6);
        offer_request(OP_QUERY, 10'd2, 10'd1022, 24'hFFFFFF);
        offer_request(OP_QUERY, 10'd2, 10'd1023, 24'd7);
        offer_request(OP_QUERY, 10'd0, 10'd1, 24'hFFFFFF);
        offer_request(OP_QUERY, 10'd1023, 10'd0, 24'd0);
        offer_request(OP_QUERY, 10'd3, 10'd3, 24'd0);
        // smaller tree hangs under the larger one
        offer_request(OP_ADD, 10'd4, 10'd5, 24'd0);
        offer_request(OP_ADD, 10'd4, 10'd1, 24'd0);
        offer_request(OP_QUERY, 10'd5, 10'd1022, 24'd0);
        offer_request(OP_QUERY, 10'd5, 10'd1022, 24'hFFFFFF);

        // disabled: adds only tick the clock, queries answer false
        drain();
        set_connect_enable(1'b0);
        offer_request(OP_ADD, 10'd6, 10'd7, 24'd0);
        offer_request(OP_QUERY, 10'd1, 10'd2, 24'hFFFFFF);
        drain();
        set_connect_enable(1'b1);
        offer_request(OP_QUERY, 10'd6, 10'd7, 24'hFFFFFF);
        offer_request(OP_ADD, 10'd6, 10'd7, 24'd0);
        offer_request(OP_QUERY, 10'd6, 10'd7, 24'hFFFFFF);

        // random, enabled
        for (int i = 0; i < 300; i++)
            random_request(i);

        // random, disabled
        drain();
        set_connect_enable(1'b0);
        for (int i = 0; i < 40; i++)
            random_request(i);

        // random, enabled, idling swapped between the two sides
        drain();
        set_connect_enable(1'b1);
        send_idle_pct = 80;
        recv_idle_pct = 31;
        for (int i = 0; i < 300; i++)
            random_request(i);

        // no idling, with one long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 160; i++)
        begin
            random_request(i);
            if (i == 20)
                pressure_req = 1'b1;
        end

        drain();
        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> sim.f
sv/tufc_pkg.sv
sv/tufc_node_ram.sv
sv/timestamped_union_find_connectivity_unit.sv
sv/tufc_checker.sv
tb/sv/connectivity_checker.sv
tb/sv/testbench.sv
